// ----- hdl/rcrt_pkg.sv -----
// shared types, constants and sizes for the row/column remap table
package rcrt_pkg;

  // matrix and value sizes
  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int VALUE_BITS = 32;

  // fixed field widths
  localparam int OP_BITS   = 2;
  localparam int IDX_BITS  = 9;
  localparam int REG_BITS  = 9;
  localparam int DATA_BITS = 32;

  // derived storage sizes
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int MAP_DEPTH  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int MAP_BITS   = $clog2(MAP_DEPTH);
  localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int CELL_BITS  = $clog2(CELL_DEPTH);

  // operation codes
  localparam logic [OP_BITS-1:0] OP_LOAD      = 2'd0;
  localparam logic [OP_BITS-1:0] OP_SWAP_COLS = 2'd1;
  localparam logic [OP_BITS-1:0] OP_SWAP_ROWS = 2'd2;
  localparam logic [OP_BITS-1:0] OP_QUERY     = 2'd3;

  // register indexes
  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  localparam logic [REG_BITS-1:0] IN_USE_RESET = 9'd256;

  typedef struct packed {
    logic [OP_BITS-1:0]  operation;
    logic [IDX_BITS-1:0] first_index;
    logic [IDX_BITS-1:0] second_index;
    logic [DATA_BITS-1:0] cell_value;
  } req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_value;
    logic                 status;
  } result_t;

  typedef struct packed {
    logic                rd_en;
    logic [MAP_BITS-1:0] rd_addr_a;
    logic [MAP_BITS-1:0] rd_addr_b;
    logic                wr_en;
    logic [MAP_BITS-1:0] wr_addr;
    logic [MAP_BITS-1:0] wr_data;
  } map_req_t;

  typedef struct packed {
    logic [MAP_BITS-1:0] a;
    logic [MAP_BITS-1:0] b;
  } map_rsp_t;

  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [CELL_BITS-1:0]  addr;
    logic [VALUE_BITS-1:0] wr_data;
  } cell_req_t;

endpackage

// ----- hdl/rcrt_map_table.sv -----
// remap table memory: two registered read ports, one write port, identity reset
module rcrt_map_table (
  input  logic               clk,
  input  logic               rst,
  input  rcrt_pkg::map_req_t req,
  output rcrt_pkg::map_rsp_t rsp
);

  logic [rcrt_pkg::MAP_BITS-1:0] mem [rcrt_pkg::MAP_DEPTH];
  logic [rcrt_pkg::MAP_DEPTH-1:0] written;

  logic [rcrt_pkg::MAP_BITS-1:0] data_a;
  logic [rcrt_pkg::MAP_BITS-1:0] data_b;
  logic [rcrt_pkg::MAP_BITS-1:0] addr_a;
  logic [rcrt_pkg::MAP_BITS-1:0] addr_b;
  logic                          valid_a;
  logic                          valid_b;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_a  <= mem[req.rd_addr_a];
      data_b  <= mem[req.rd_addr_b];
      valid_a <= written[req.rd_addr_a];
      valid_b <= written[req.rd_addr_b];
      addr_a  <= req.rd_addr_a;
      addr_b  <= req.rd_addr_b;
    end
  end

  // entries never written read as their own index
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.wr_en) begin
      written[req.wr_addr] <= 1'b1;
    end
  end

  assign rsp.a = valid_a ? data_a : addr_a;
  assign rsp.b = valid_b ? data_b : addr_b;

endmodule

// ----- hdl/rcrt_cell_store.sv -----
// matrix cell memory with one port and registered read data
module rcrt_cell_store (
  input  logic                              clk,
  input  rcrt_pkg::cell_req_t               req,
  output logic [rcrt_pkg::VALUE_BITS-1:0]   rd_data
);

  logic [rcrt_pkg::VALUE_BITS-1:0] mem [rcrt_pkg::CELL_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// ----- hdl/row_column_remap_table.sv -----
// top level of the row/column remap table with its register port
// usage:
//   a request is taken at a rising edge with start high and busy low.
//   load writes one physical cell, swap exchanges two entries of the row or
//   column table, query reads the cell at the remapped row and column.
//   indices are 1-based; an index of zero or beyond the rows or columns in
//   use makes a load or swap do nothing and a query return status 1.
// timing:
//   loads and queries never raise busy, so a new request can enter every
//   cycle while busy is low. a query result shows on result with
//   result_valid high for one cycle, registered through stage 1 and stage 2.
//   a valid swap holds busy through stage 1 and phase2 after it is taken:
//   each table has one write port, so the two entries are written in turn.
//   the receiver has no way to hold results off; none are dropped.
// reset:
//   rows_in_use and cols_in_use return to 256, both tables to the identity
//   (per-entry written bits are cleared at once, no sweep). cells are
//   undefined until loaded.
// registers (apb, pready always high): rows_in_use at 0x0, cols_in_use at 0x4
module row_column_remap_table (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               start,
  output logic               busy,
  input  rcrt_pkg::req_t     req,
  // result channel
  output logic               result_valid,
  output rcrt_pkg::result_t  result,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [rcrt_pkg::REG_BITS-1:0] rows_in_use;
  logic [rcrt_pkg::REG_BITS-1:0] cols_in_use;

  // stage 1: accepted request, table reads in flight
  logic                                 s1_valid;
  logic                                 s1_ok;
  logic [rcrt_pkg::OP_BITS-1:0]         s1_op;
  logic [rcrt_pkg::MAP_BITS-1:0]        s1_p_addr;
  logic [rcrt_pkg::MAP_BITS-1:0]        s1_q_addr;
  logic [rcrt_pkg::VALUE_BITS-1:0]      s1_value;
  // second write of a swap
  logic                                 phase2;
  // stage 2: query result waiting on cell read data
  logic                                 s2_valid;
  logic                                 s2_ok;

  logic                                 accept;
  logic                                 s1_swap;
  logic                                 ok_next;
  logic                                 row_p_ok;
  logic                                 row_q_ok;
  logic                                 col_p_ok;
  logic                                 col_q_ok;
  logic [rcrt_pkg::MAP_BITS-1:0]        p_addr;
  logic [rcrt_pkg::MAP_BITS-1:0]        q_addr;

  rcrt_pkg::map_req_t                   row_req;
  rcrt_pkg::map_rsp_t                   row_rsp;
  rcrt_pkg::map_req_t                   col_req;
  rcrt_pkg::map_rsp_t                   col_rsp;
  rcrt_pkg::cell_req_t                  cell_req;
  logic [rcrt_pkg::VALUE_BITS-1:0]      cell_data;
  logic [rcrt_pkg::CELL_BITS-1:0]       phys_addr;
  logic [rcrt_pkg::CELL_BITS-1:0]       remap_addr;

  function automatic logic index_ok(input logic [rcrt_pkg::IDX_BITS-1:0] idx,
                                    input logic [rcrt_pkg::REG_BITS-1:0] limit,
                                    input int max_idx);
    index_ok = (idx != '0) && (idx <= limit) && (32'(idx) <= 32'(max_idx));
  endfunction

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rcrt_pkg::REG_COLS_IN_USE) ? 32'(cols_in_use)
                                                          : 32'(rows_in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= rcrt_pkg::IN_USE_RESET;
      cols_in_use <= rcrt_pkg::IN_USE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == rcrt_pkg::REG_ROWS_IN_USE) begin
        rows_in_use <= pwdata[rcrt_pkg::REG_BITS-1:0];
      end else begin
        cols_in_use <= pwdata[rcrt_pkg::REG_BITS-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- accept
  // a valid swap blocks new requests until both table writes have landed
  assign s1_swap = s1_valid && s1_ok &&
                   (s1_op inside {rcrt_pkg::OP_SWAP_COLS, rcrt_pkg::OP_SWAP_ROWS});
  assign busy    = s1_swap || phase2;
  assign accept  = start && !busy;

  assign row_p_ok = index_ok(req.first_index,  rows_in_use, rcrt_pkg::MAX_ROWS);
  assign row_q_ok = index_ok(req.second_index, rows_in_use, rcrt_pkg::MAX_ROWS);
  assign col_p_ok = index_ok(req.first_index,  cols_in_use, rcrt_pkg::MAX_COLS);
  assign col_q_ok = index_ok(req.second_index, cols_in_use, rcrt_pkg::MAX_COLS);

  // 1-based index to 0-based table address
  assign p_addr = rcrt_pkg::MAP_BITS'(req.first_index  - rcrt_pkg::IDX_BITS'(1));
  assign q_addr = rcrt_pkg::MAP_BITS'(req.second_index - rcrt_pkg::IDX_BITS'(1));

  always_comb begin
    case (req.operation)
      rcrt_pkg::OP_LOAD:      ok_next = row_p_ok && col_q_ok;
      rcrt_pkg::OP_SWAP_COLS: ok_next = col_p_ok && col_q_ok;
      rcrt_pkg::OP_SWAP_ROWS: ok_next = row_p_ok && row_q_ok;
      default:                ok_next = row_p_ok && col_q_ok;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase2   <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      phase2   <= s1_swap;
      s2_valid <= s1_valid && (s1_op == rcrt_pkg::OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok     <= ok_next;
      s1_op     <= req.operation;
      s1_p_addr <= p_addr;
      s1_q_addr <= q_addr;
      s1_value  <= rcrt_pkg::VALUE_BITS'(req.cell_value);
    end
    s2_ok <= s1_ok;
  end

  // ---------------------------------------------------------------- tables
  // both tables read at the accepted indices; a query uses row port a
  // and column port b, a swap uses both ports of its own table.
  // swap writes entry p with old q first, then entry q with old p
  always_comb begin
    row_req.rd_en     = accept;
    row_req.rd_addr_a = p_addr;
    row_req.rd_addr_b = q_addr;
    row_req.wr_en     = (s1_swap || phase2) && (s1_op == rcrt_pkg::OP_SWAP_ROWS);
    row_req.wr_addr   = phase2 ? s1_q_addr : s1_p_addr;
    row_req.wr_data   = phase2 ? row_rsp.a : row_rsp.b;

    col_req.rd_en     = accept;
    col_req.rd_addr_a = p_addr;
    col_req.rd_addr_b = q_addr;
    col_req.wr_en     = (s1_swap || phase2) && (s1_op == rcrt_pkg::OP_SWAP_COLS);
    col_req.wr_addr   = phase2 ? s1_q_addr : s1_p_addr;
    col_req.wr_data   = phase2 ? col_rsp.a : col_rsp.b;
  end

  rcrt_map_table u_row_map (
    .clk (clk),
    .rst (rst),
    .req (row_req),
    .rsp (row_rsp)
  );

  rcrt_map_table u_col_map (
    .clk (clk),
    .rst (rst),
    .req (col_req),
    .rsp (col_rsp)
  );

  // ---------------------------------------------------------------- cells
  // loads address the physical cell, queries the remapped one; both act
  // in stage 1, so they stay in request order
  assign phys_addr =
    rcrt_pkg::CELL_BITS'(rcrt_pkg::ROW_BITS'(s1_p_addr)) *
      rcrt_pkg::CELL_BITS'(rcrt_pkg::MAX_COLS) +
    rcrt_pkg::CELL_BITS'(rcrt_pkg::COL_BITS'(s1_q_addr));

  assign remap_addr =
    rcrt_pkg::CELL_BITS'(rcrt_pkg::ROW_BITS'(row_rsp.a)) *
      rcrt_pkg::CELL_BITS'(rcrt_pkg::MAX_COLS) +
    rcrt_pkg::CELL_BITS'(rcrt_pkg::COL_BITS'(col_rsp.b));

  always_comb begin
    cell_req.wr_en   = s1_valid && s1_ok && (s1_op == rcrt_pkg::OP_LOAD);
    cell_req.rd_en   = s1_valid && s1_ok && (s1_op == rcrt_pkg::OP_QUERY);
    cell_req.addr    = (s1_op == rcrt_pkg::OP_LOAD) ? phys_addr : remap_addr;
    cell_req.wr_data = s1_value;
  end

  rcrt_cell_store u_cells (
    .clk     (clk),
    .req     (cell_req),
    .rd_data (cell_data)
  );

  // ---------------------------------------------------------------- result
  // out-of-range query gives zero with status set
  assign result_valid      = s2_valid;
  assign result.read_value = s2_ok ? rcrt_pkg::DATA_BITS'(cell_data) : '0;
  assign result.status     = !s2_ok;

endmodule

// ----- tb/tb_row_column_remap_table.sv -----
// self-checking testbench for the row/column remap table: loads, swaps and queries
module tb_row_column_remap_table;
  timeunit 1ns;
  timeprecision 1ps;

  // idle cycles without any accepted request, result or register write
  localparam int unsigned STALL_LIMIT = 2000;
  // cycles to let a swap finish after the last query result has come
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned PHASES = 8;
  // rows and columns in use for each random phase, zero means pick at random
  localparam int unsigned ROWS_SETTING [PHASES] = '{256, 1, 4, 256, 1, 3, 16, 0};
  localparam int unsigned COLS_SETTING [PHASES] = '{256, 1, 4, 1, 256, 7, 16, 0};

  // tracks the remap tables and the cell store, and holds the query results
  // still to come
  class remap_scoreboard;
    bit [rcrt_pkg::ROW_BITS-1:0]  row_map [rcrt_pkg::MAX_ROWS];
    bit [rcrt_pkg::COL_BITS-1:0]  col_map [rcrt_pkg::MAX_COLS];
    bit [rcrt_pkg::DATA_BITS-1:0] cell_store [rcrt_pkg::CELL_DEPTH];
    bit                           cell_written [rcrt_pkg::CELL_DEPTH];
    int unsigned                  written_cells [$];
    bit [rcrt_pkg::REG_BITS-1:0]  rows_in_use;
    bit [rcrt_pkg::REG_BITS-1:0]  cols_in_use;
    rcrt_pkg::result_t            expected_results [$];
    int unsigned                  errors;

    function new();
      for (int i = 0; i < rcrt_pkg::MAX_ROWS; i++) row_map[i] = rcrt_pkg::ROW_BITS'(i);
      for (int i = 0; i < rcrt_pkg::MAX_COLS; i++) col_map[i] = rcrt_pkg::COL_BITS'(i);
      rows_in_use = rcrt_pkg::IN_USE_RESET;
      cols_in_use = rcrt_pkg::IN_USE_RESET;
      errors = 0;
    endfunction

    function void set_register(logic idx, int unsigned value);
      if (idx == rcrt_pkg::REG_ROWS_IN_USE) begin
        rows_in_use = value[rcrt_pkg::REG_BITS-1:0];
      end else begin
        cols_in_use = value[rcrt_pkg::REG_BITS-1:0];
      end
    endfunction

    function bit row_valid(int unsigned idx);
      return idx >= 1 && idx <= rows_in_use && idx <= rcrt_pkg::MAX_ROWS;
    endfunction

    function bit col_valid(int unsigned idx);
      return idx >= 1 && idx <= cols_in_use && idx <= rcrt_pkg::MAX_COLS;
    endfunction

    // 1-based logical row that maps onto a physical row, 0 if none in use
    function int unsigned find_row(int unsigned phys);
      for (int i = 0; i < rows_in_use && i < rcrt_pkg::MAX_ROWS; i++) begin
        if (row_map[i] == phys) return i + 1;
      end
      return 0;
    endfunction

    function int unsigned find_col(int unsigned phys);
      for (int i = 0; i < cols_in_use && i < rcrt_pkg::MAX_COLS; i++) begin
        if (col_map[i] == phys) return i + 1;
      end
      return 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_request(rcrt_pkg::req_t r);
      int unsigned p;
      int unsigned q;
      int unsigned cell_idx;
      bit [rcrt_pkg::ROW_BITS-1:0] row_tmp;
      bit [rcrt_pkg::COL_BITS-1:0] col_tmp;
      rcrt_pkg::result_t res;
      p = r.first_index;
      q = r.second_index;
      case (r.operation)
        rcrt_pkg::OP_LOAD: begin
          // loads go to the physical cell, no remapping
          if (row_valid(p) && col_valid(q)) begin
            cell_idx = (p - 1) * rcrt_pkg::MAX_COLS + (q - 1);
            if (!cell_written[cell_idx]) begin
              cell_written[cell_idx] = 1'b1;
              written_cells = {written_cells, cell_idx};
            end
            cell_store[cell_idx] = r.cell_value;
          end
        end
        rcrt_pkg::OP_SWAP_COLS: begin
          if (col_valid(p) && col_valid(q)) begin
            col_tmp = col_map[p-1];
            col_map[p-1] = col_map[q-1];
            col_map[q-1] = col_tmp;
          end
        end
        rcrt_pkg::OP_SWAP_ROWS: begin
          if (row_valid(p) && row_valid(q)) begin
            row_tmp = row_map[p-1];
            row_map[p-1] = row_map[q-1];
            row_map[q-1] = row_tmp;
          end
        end
        default: begin
          res = '0;
          if (row_valid(p) && col_valid(q)) begin
            res.read_value = cell_store[row_map[p-1] * rcrt_pkg::MAX_COLS + col_map[q-1]];
          end else begin
            res.status = 1'b1;
          end
          expected_results = {expected_results, res};
        end
      endcase
    endfunction

    function void check_result(rcrt_pkg::result_t got);
      rcrt_pkg::result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no query waiting: value %h status %0d",
                   $realtime, got.read_value, got.status);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_value !== want.read_value || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("%0t: query result: expected value %h status %0d, got value %h status %0d",
                   $realtime, want.read_value, want.status, got.read_value, got.status);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  rcrt_pkg::req_t    req;
  logic              result_valid;
  rcrt_pkg::result_t result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  remap_scoreboard sb = new();
  int unsigned     stall_count = 0;

  row_column_remap_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // sample at the rising edge: a request is taken when start is high and busy
  // low, a result when result_valid is high; outputs still hold their pre-edge
  // values here since the block updates them with nonblocking assignments
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (result_valid) sb.check_result(result);
      if ((start && !busy) || result_valid || (psel && penable)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      // watchdog: nothing has moved for far longer than any gap or drain
      if (stall_count >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic rcrt_pkg::req_t make_req(logic [rcrt_pkg::OP_BITS-1:0] op,
                                              int unsigned p, int unsigned q,
                                              logic [rcrt_pkg::DATA_BITS-1:0] value);
    rcrt_pkg::req_t r;
    r.operation    = op;
    r.first_index  = rcrt_pkg::IDX_BITS'(p);
    r.second_index = rcrt_pkg::IDX_BITS'(q);
    r.cell_value   = value;
    return r;
  endfunction

  // an index that is out of range for a limit in use: zero or past the limit
  function automatic int unsigned bad_index(int unsigned limit);
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(limit + 1, (1 << rcrt_pkg::IDX_BITS) - 1);
  endfunction

  // query aimed at a cell that was loaded, found through the inverse of the
  // current tables; falls back to an out-of-range query when no loaded cell
  // is reachable with the rows and columns in use
  function automatic rcrt_pkg::req_t pick_query();
    int unsigned cell_idx;
    int unsigned p;
    int unsigned q;
    for (int tries = 0; tries < 8 && sb.written_cells.size() > 0; tries++) begin
      cell_idx = sb.written_cells[$urandom_range(0, sb.written_cells.size() - 1)];
      p = sb.find_row(cell_idx / rcrt_pkg::MAX_COLS);
      q = sb.find_col(cell_idx % rcrt_pkg::MAX_COLS);
      if (p != 0 && q != 0) return make_req(rcrt_pkg::OP_QUERY, p, q, $urandom());
    end
    return make_req(rcrt_pkg::OP_QUERY, bad_index(sb.rows_in_use), $urandom_range(0, 511),
                    $urandom());
  endfunction

  function automatic rcrt_pkg::req_t random_request();
    int unsigned rows;
    int unsigned cols;
    int unsigned sel;
    int unsigned p;
    int unsigned q;
    int unsigned n;
    int unsigned pr;
    int unsigned pc;
    logic [rcrt_pkg::OP_BITS-1:0] op;
    rows = sb.rows_in_use;
    cols = sb.cols_in_use;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      p = $urandom_range(1, rows);
      q = $urandom_range(1, cols);
      if ($urandom_range(0, 9) == 0) begin
        // load that must be dropped
        if ($urandom_range(0, 1)) p = bad_index(rows);
        else q = bad_index(cols);
      end else if ($urandom_range(0, 1)) begin
        // fill the physical cell a logical query would reach, if in range
        pr = sb.row_map[p-1];
        pc = sb.col_map[q-1];
        if (pr < rows && pc < cols) begin
          p = pr + 1;
          q = pc + 1;
        end
      end
      return make_req(rcrt_pkg::OP_LOAD, p, q, $urandom());
    end
    if (sel < 65) begin
      op = (sel < 50) ? rcrt_pkg::OP_SWAP_COLS : rcrt_pkg::OP_SWAP_ROWS;
      n = (op == rcrt_pkg::OP_SWAP_COLS) ? cols : rows;
      p = $urandom_range(1, n);
      q = $urandom_range(1, n);
      sel = $urandom_range(0, 99);
      // swap with itself, or one index out of range
      if (sel < 10) q = p;
      else if (sel < 18) q = bad_index(n);
      else if (sel < 26) p = bad_index(n);
      return make_req(op, p, q, $urandom());
    end
    if (sel < 92) return pick_query();
    if ($urandom_range(0, 1)) return make_req(rcrt_pkg::OP_QUERY, bad_index(rows),
                                              $urandom_range(1, cols), $urandom());
    return make_req(rcrt_pkg::OP_QUERY, $urandom_range(1, rows), bad_index(cols), $urandom());
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned gap_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // start low with junk on the request bus
  task automatic idle_cycles(input int unsigned n);
    rcrt_pkg::req_t junk;
    repeat (n) begin
      @(negedge clk);
      junk.operation    = rcrt_pkg::OP_BITS'($urandom_range(0, 3));
      junk.first_index  = rcrt_pkg::IDX_BITS'($urandom_range(0, 511));
      junk.second_index = rcrt_pkg::IDX_BITS'($urandom_range(0, 511));
      junk.cell_value   = $urandom();
      start <= 1'b0;
      req   <= junk;
    end
  endtask

  // hold the request until it is taken; returns just after the taking edge
  task automatic send_request(input rcrt_pkg::req_t r);
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // as send_request, but the request is drawn at the falling edge, once the
  // scoreboard has seen the request taken at the edge before
  task automatic send_random_request();
    rcrt_pkg::req_t r;
    @(negedge clk);
    r = random_request();
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // let every query result arrive, then give a pending swap time to finish
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup phase, then access phase; pready is always high
  task automatic write_register(input logic idx, input int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rcrt_pkg::req_t directed [$];
    int unsigned    rows;
    int unsigned    cols;
    bit             no_idle;

    clk     = 1'b0;
    rst     = 1'b1;
    start   = 1'b0;
    req     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_register(rcrt_pkg::REG_ROWS_IN_USE, 256);
    write_register(rcrt_pkg::REG_COLS_IN_USE, 256);

    // corners of the full matrix, all-zero and all-one values
    directed = {directed, make_req(rcrt_pkg::OP_LOAD, 1, 1, 32'h0000_0000)};
    directed = {directed, make_req(rcrt_pkg::OP_LOAD, 256, 256, 32'hffff_ffff)};
    directed = {directed, make_req(rcrt_pkg::OP_LOAD, 1, 256, 32'ha5a5_a5a5)};
    directed = {directed, make_req(rcrt_pkg::OP_LOAD, 256, 1, 32'h5a5a_5a5a)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 1, 1, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 256, 256, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 1, 256, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 256, 1, 32'h0)};
    // swaps of the outermost columns and rows, then queries through them
    directed = {directed, make_req(rcrt_pkg::OP_SWAP_COLS, 1, 256, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 1, 1, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 256, 256, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_SWAP_ROWS, 1, 256, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 1, 1, 32'h0)};
    // swap with itself changes nothing
    directed = {directed, make_req(rcrt_pkg::OP_SWAP_COLS, 7, 7, 32'h0)};
    // swaps and loads with an index of zero or past the end are dropped
    directed = {directed, make_req(rcrt_pkg::OP_SWAP_ROWS, 0, 3, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_SWAP_COLS, 257, 1, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_SWAP_ROWS, 2, 511, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_LOAD, 0, 5, 32'h1234_5678)};
    directed = {directed, make_req(rcrt_pkg::OP_LOAD, 257, 1, 32'h8765_4321)};
    // out-of-range queries give status 1 and a zero value; the last query is in range
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 0, 1, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 1, 0, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 257, 256, 32'h0)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 511, 511, 32'hffff_ffff)};
    directed = {directed, make_req(rcrt_pkg::OP_QUERY, 256, 1, 32'h0)};

    foreach (directed[i]) begin
      idle_cycles(gap_length());
      send_request(directed[i]);
    end

    // random phases, registers rewritten only once the block is idle
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      rows = (ROWS_SETTING[ph] != 0) ? ROWS_SETTING[ph] : $urandom_range(1, 256);
      cols = (COLS_SETTING[ph] != 0) ? COLS_SETTING[ph] : $urandom_range(1, 256);
      if ($urandom_range(0, 1)) begin
        write_register(rcrt_pkg::REG_ROWS_IN_USE, rows);
        write_register(rcrt_pkg::REG_COLS_IN_USE, cols);
      end else begin
        write_register(rcrt_pkg::REG_COLS_IN_USE, cols);
        write_register(rcrt_pkg::REG_ROWS_IN_USE, rows);
      end
      // some phases run back to back with no idling at all
      no_idle = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!no_idle) idle_cycles(gap_length());
        send_random_request();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rcrt_pkg.sv
hdl/rcrt_map_table.sv
hdl/rcrt_cell_store.sv
hdl/row_column_remap_table.sv
tb/tb_row_column_remap_table.sv
